### design/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau assertion failed");
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/rau_pkg.sv
// Types and constants shared by the rational arithmetic unit
package rau_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned MagW  = 64;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_INV  = 3'd4;
  localparam logic [2:0] MODE_NORM = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic signed [31:0] left_num;
    logic signed [31:0] left_den;
    logic signed [31:0] right_num;
    logic signed [31:0] right_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic is_zero;
    logic is_none;
    logic overflow;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_NORM_L, S_NORM_R, S_MUL0, S_MUL1, S_MUL2, S_COMB,
    S_NORM_RES, S_DONE
  } state_t;

  // Normaliser states
  typedef enum logic [2:0] {N_IDLE, N_GCD, N_DIVN, N_DIVD} norm_state_t;
endpackage

### design/rau_norm.sv
// Iterative fraction normaliser: binary gcd then two serial divisions
module rau_norm (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic num_neg,
  input  logic [rau_pkg::MagW-1:0] num_in,
  input  logic den_neg,
  input  logic [rau_pkg::MagW-1:0] den_in,
  output logic busy,
  output logic res_neg,
  output logic [rau_pkg::MagW-1:0] res_num,
  output logic [rau_pkg::MagW-1:0] res_den
);
  localparam int unsigned CW = $clog2(rau_pkg::MagW + 1);

  rau_pkg::norm_state_t state, state_next;
  logic [rau_pkg::MagW-1:0] ga, gb;
  logic [CW-1:0] shift;
  logic [rau_pkg::MagW-1:0] g;
  logic [rau_pkg::MagW-1:0] dvd, quo, rem;
  logic [CW-1:0] cnt;
  logic [rau_pkg::MagW:0] trial;

  assign busy = (state != rau_pkg::N_IDLE);
  assign g = gb << shift;
  assign trial = {rem, dvd[rau_pkg::MagW-1]} - {1'b0, g};

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::N_IDLE: if (start) begin
        if (den_in == '0 || den_in == 64'd1) state_next = rau_pkg::N_IDLE;
        else state_next = rau_pkg::N_GCD;
      end
      rau_pkg::N_GCD:  if (ga == '0) state_next = rau_pkg::N_DIVN;
      rau_pkg::N_DIVN: if (cnt == CW'(rau_pkg::MagW - 1)) state_next = rau_pkg::N_DIVD;
      rau_pkg::N_DIVD: if (cnt == CW'(rau_pkg::MagW - 1)) state_next = rau_pkg::N_IDLE;
      default: state_next = rau_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rau_pkg::N_IDLE;
    else state <= state_next;
  end

  // Datapath: binary gcd steps, then restoring division one bit a cycle
  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::N_IDLE: if (start) begin
        if (den_in == '0) begin
          res_neg <= 1'b0;
          res_num <= 64'd1;
        end else begin
          res_neg <= (num_neg != den_neg) && num_in != '0;
          res_num <= num_in;
        end
        res_den <= den_in;
        ga <= num_in;
        gb <= den_in;
        shift <= '0;
        cnt <= '0;
      end
      rau_pkg::N_GCD: begin
        // gb stays nonzero; ga driven to zero
        if (ga == '0) begin
          dvd <= res_num;
          rem <= '0;
          cnt <= '0;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1; gb <= gb >> 1; shift <= shift + 1'b1;
        end else if (!ga[0]) ga <= ga >> 1;
        else if (!gb[0]) gb <= gb >> 1;
        else if (ga >= gb) ga <= (ga - gb) >> 1;
        else begin
          gb <= ga; ga <= (gb - ga) >> 1;
        end
      end
      rau_pkg::N_DIVN, rau_pkg::N_DIVD: begin
        if (cnt == CW'(rau_pkg::MagW - 1)) begin
          cnt <= '0;
          rem <= '0;
          if (state == rau_pkg::N_DIVN) begin
            res_num <= {quo[rau_pkg::MagW-2:0], ~trial[rau_pkg::MagW]};
            dvd <= res_den;
          end else begin
            res_den <= {quo[rau_pkg::MagW-2:0], ~trial[rau_pkg::MagW]};
            if (res_num == '0) res_neg <= 1'b0;
          end
        end else begin
          if (!trial[rau_pkg::MagW]) begin
            rem <= trial[rau_pkg::MagW-1:0];
            quo <= {quo[rau_pkg::MagW-2:0], 1'b1};
          end else begin
            rem <= {rem[rau_pkg::MagW-2:0], dvd[rau_pkg::MagW-1]};
            quo <= {quo[rau_pkg::MagW-2:0], 1'b0};
          end
          dvd <= dvd << 1;
          cnt <= cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

### design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit
// Sequencing: a normalisation does no gcd or division when its denominator is 0 or 1;
// otherwise it runs a binary gcd and then two serial divisions, numerator then denominator.
// Throughput: one item at a time; busy falls in the strobe cycle, the receiver never stalls.
// Reset (rst, synchronous, active high) returns the sequencer to idle.
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  rau_pkg::in_item_t  in_item,
  output logic done,
  output rau_pkg::out_item_t out_item
);
  localparam int unsigned MW = rau_pkg::MagW;
  localparam logic [MW-1:0] Half = MW'(64'd1 << (rau_pkg::Width - 1));

  rau_pkg::state_t state, state_next;
  rau_pkg::in_item_t item;
  logic norm_start, norm_busy;

  logic ln_neg, rn_neg;
  logic [31:0] ln, ld, rn, rd;
  logic [MW-1:0] p0, p1, p2;
  logic p0n, p1n;
  logic [31:0] ma, mb;
  logic [MW-1:0] prod;

  logic n_nneg, n_dneg, n_rneg;
  logic [MW-1:0] n_num, n_den, n_rnum, n_rden;

  // Field magnitude; the sign is bit 31 of the field
  function automatic logic [MW-1:0] mag_of(input logic [31:0] v);
    return v[31] ? MW'(32'(-v)) | (v == 32'h8000_0000 ? Half : '0) : MW'(v);
  endfunction

  assign busy = (state != rau_pkg::S_IDLE);
  assign prod = MW'(ma) * MW'(mb);

  // Shared multiplier operands
  always_comb begin
    ma = ln; mb = rd;
    case (state)
      rau_pkg::S_MUL0: begin
        ma = ln; mb = (item.mode == rau_pkg::MODE_MUL) ? rn : rd;
      end
      rau_pkg::S_MUL1: begin
        ma = (item.mode == rau_pkg::MODE_ADD || item.mode == rau_pkg::MODE_SUB) ? rn : ld;
        mb = (item.mode == rau_pkg::MODE_ADD || item.mode == rau_pkg::MODE_SUB) ? ld :
             (item.mode == rau_pkg::MODE_MUL) ? rd : rn;
      end
      rau_pkg::S_MUL2: begin ma = ld; mb = rd; end
      default: ;
    endcase
  end

  // Normaliser operand selection
  always_comb begin
    n_nneg = 1'b0; n_num = '0; n_dneg = 1'b0; n_den = '0;
    case (state)
      rau_pkg::S_NORM_L: begin
        n_nneg = item.left_num[31]; n_num = mag_of(item.left_num);
        n_dneg = item.left_den[31]; n_den = mag_of(item.left_den);
      end
      rau_pkg::S_NORM_R: begin
        n_nneg = item.right_num[31]; n_num = mag_of(item.right_num);
        n_dneg = item.right_den[31]; n_den = mag_of(item.right_den);
      end
      default: begin
        n_nneg = p0n; n_num = p0; n_dneg = p1n; n_den = p1;
      end
    endcase
  end

  rau_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start),
    .num_neg(n_nneg), .num_in(n_num), .den_neg(n_dneg), .den_in(n_den),
    .busy(norm_busy), .res_neg(n_rneg), .res_num(n_rnum), .res_den(n_rden)
  );

  logic launched;

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::S_IDLE: if (start) state_next = rau_pkg::S_NORM_L;
      rau_pkg::S_NORM_L: if (launched && !norm_busy)
        state_next = (item.mode >= rau_pkg::MODE_INV) ? rau_pkg::S_COMB : rau_pkg::S_NORM_R;
      rau_pkg::S_NORM_R: if (launched && !norm_busy) state_next = rau_pkg::S_MUL0;
      rau_pkg::S_MUL0: state_next = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_next = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: state_next = rau_pkg::S_COMB;
      rau_pkg::S_COMB: state_next = rau_pkg::S_NORM_RES;
      rau_pkg::S_NORM_RES: if (launched && !norm_busy) state_next = rau_pkg::S_DONE;
      rau_pkg::S_DONE: state_next = rau_pkg::S_IDLE;
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    norm_start = 1'b0;
    if ((state == rau_pkg::S_NORM_L || state == rau_pkg::S_NORM_R ||
         state == rau_pkg::S_NORM_RES) && !launched)
      norm_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      launched <= (state_next == state) && (launched || norm_start);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::S_IDLE: if (start) item <= in_item;
      rau_pkg::S_NORM_L: if (launched && !norm_busy) begin
        ln_neg <= n_rneg; ln <= n_rnum[31:0]; ld <= n_rden[31:0];
      end
      rau_pkg::S_NORM_R: if (launched && !norm_busy) begin
        rn_neg <= n_rneg; rn <= n_rnum[31:0]; rd <= n_rden[31:0];
      end
      rau_pkg::S_MUL0: p0 <= prod;
      rau_pkg::S_MUL1: p1 <= prod;
      rau_pkg::S_MUL2: p2 <= prod;
      rau_pkg::S_COMB: begin
        case (item.mode)
          rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
            // signed add of the cross products over common denominator
            if ((ln_neg && p0 != '0) ==
                (((item.mode == rau_pkg::MODE_SUB) ^ rn_neg) && p1 != '0)) begin
              p0 <= p0 + p1; p0n <= ln_neg && p0 != '0;
            end else if (p0 >= p1) begin
              p0 <= p0 - p1; p0n <= ln_neg && p0 != '0;
            end else begin
              p0 <= p1 - p0; p0n <= ((item.mode == rau_pkg::MODE_SUB) ^ rn_neg) && p1 != '0;
            end
            p1 <= p2; p1n <= 1'b0;
          end
          rau_pkg::MODE_MUL: begin
            p0n <= ln_neg != rn_neg; p1 <= p2; p1n <= 1'b0;
          end
          rau_pkg::MODE_DIV: begin
            p0n <= ln_neg; p1n <= rn_neg;
          end
          rau_pkg::MODE_INV: begin
            p0 <= MW'(ld); p0n <= 1'b0; p1 <= MW'(ln); p1n <= ln_neg;
          end
          default: begin
            p0 <= MW'(ln); p0n <= ln_neg; p1 <= MW'(ld); p1n <= 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Result formatting
  logic [MW-1:0] snum;
  logic ovf;
  always_comb begin
    snum = n_rneg ? -n_rnum : n_rnum;
    ovf = (n_rneg ? (n_rnum > Half) : (n_rnum > Half - 1)) || (n_rden > Half - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == rau_pkg::S_DONE);
  end

  always_ff @(posedge clk) begin
    if (state == rau_pkg::S_DONE) begin
      out_item.res_num  <= snum[31:0];
      out_item.res_den  <= n_rden[30:0];
      out_item.is_zero  <= (n_rnum == '0) && (n_rden != '0);
      out_item.is_none  <= (n_rden == '0);
      out_item.overflow <= ovf;
    end
  end

  `RAU_ASSERT_NXT(a_done_once, clk, rst, done, !done)
  `RAU_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `RAU_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule
